>>> sv/lswc_pkg.sv
// shared types, outcode bits and register indexes for the line segment clipper
package lswc_pkg;

  localparam int unsigned CfgIdxBits = 2;
  localparam logic [CfgIdxBits-1:0] RegLeft   = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegTop    = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegRight  = 2'd2;
  localparam logic [CfgIdxBits-1:0] RegBottom = 2'd3;

  localparam int unsigned CodeLeft  = 0;
  localparam int unsigned CodeRight = 1;
  localparam int unsigned CodeBelow = 2;
  localparam int unsigned CodeAbove = 3;

  localparam int unsigned CapBits = 40;

  typedef logic [3:0] region_t;

endpackage

>>> sv/lswc_div_cell.sv
// one restoring division step cell of the quotient chain
module lswc_div_cell #(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 17
) (
  input  logic                     clk_i,
  input  logic [NumW-1:0]          rem_i,
  input  logic [NumW-1:0]          quo_i,
  input  logic [DenW-1:0]          den_i,
  input  logic [$clog2(NumW)-1:0]  shift_i,
  output logic [NumW-1:0]          rem_o,
  output logic [NumW-1:0]          quo_o
);

  logic [NumW+DenW-1:0] trial;
  logic                 take;

  always_comb begin
    trial = {{NumW{1'b0}}, den_i} << shift_i;
    take  = {{DenW{1'b0}}, rem_i} >= trial;
  end

  always_ff @(posedge clk_i) begin
    rem_o <= take ? rem_i - trial[NumW-1:0] : rem_i;
    quo_o <= take ? (quo_i | (NumW'(1) << shift_i)) : quo_i;
  end

endmodule

>>> sv/line_segment_window_clipper.sv
// top level of the line segment window clipper
//
// channel   dir   handshake            payload
// config    in    cfg_we_i             cfg_idx_i, cfg_data_i
// segment   in    start_i & !busy_o    x_start_i y_start_i x_end_i y_end_i
// result    out   done_o (one cycle)   visible_o clip_*_o start_region_o end_region_o
//
// one word enters each cycle, busy_o stays low
// each word is carried through these registered stages in order:
// outcode stage, product stage, 2*COORD_BITS+4 divider cells (one quotient
// bit per cell, four rows side by side) and the output stage
// reset brings the window to left 50, top 50, right 100, bottom 80
// the receiver cannot stall, so nothing waits in the chain
module line_segment_window_clipper #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [COORD_BITS-1:0] cfg_data_i,
  input  logic [COORD_BITS-1:0] x_start_i,
  input  logic [COORD_BITS-1:0] y_start_i,
  input  logic [COORD_BITS-1:0] x_end_i,
  input  logic [COORD_BITS-1:0] y_end_i,
  output logic                  done_o,
  output logic                  visible_o,
  output logic [COORD_BITS-1:0] clip_x_start_o,
  output logic [COORD_BITS-1:0] clip_y_start_o,
  output logic [COORD_BITS-1:0] clip_x_end_o,
  output logic [COORD_BITS-1:0] clip_y_end_o,
  output logic [3:0]            start_region_o,
  output logic [3:0]            end_region_o
);

  // working width: coordinates and differences
  localparam int unsigned W   = COORD_BITS + 2;
  localparam int unsigned PW  = 2 * W;          // product magnitude width
  localparam int unsigned DW  = W;              // divisor magnitude width
  localparam int unsigned NW  = 64;             // signed working width
  localparam int unsigned NumDiv = PW;          // quotient bits per row
  localparam int unsigned SW  = $clog2(PW);     // shift amount width
  localparam int unsigned QW  = PW + lswc_pkg::CapBits + 1;  // cap compare width

  typedef logic signed [NW-1:0] wide_t;

  logic signed [COORD_BITS-1:0] left_q, top_q, right_q, bottom_q;

  assign busy_o = 1'b0;

  // window registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= COORD_BITS'(50);
      top_q    <= COORD_BITS'(50);
      right_q  <= COORD_BITS'(100);
      bottom_q <= COORD_BITS'(80);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lswc_pkg::RegLeft:   left_q   <= cfg_data_i;
        lswc_pkg::RegTop:    top_q    <= cfg_data_i;
        lswc_pkg::RegRight:  right_q  <= cfg_data_i;
        lswc_pkg::RegBottom: bottom_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  wide_t wl, wt, wr, wb;
  assign wl = wide_t'(left_q);
  assign wt = wide_t'(top_q);
  assign wr = wide_t'(right_q);
  assign wb = wide_t'(bottom_q);

  function automatic lswc_pkg::region_t outc(wide_t x, wide_t y, wide_t l, wide_t t,
                                             wide_t r, wide_t b);
    lswc_pkg::region_t c;
    c = '0;
    if (x < l) c[lswc_pkg::CodeLeft] = 1'b1;
    else if (x > r) c[lswc_pkg::CodeRight] = 1'b1;
    if (y < t) c[lswc_pkg::CodeAbove] = 1'b1;
    else if (y > b) c[lswc_pkg::CodeBelow] = 1'b1;
    return c;
  endfunction

  // stage record carried through the chain
  typedef struct packed {
    lswc_pkg::region_t       ca;
    lswc_pkg::region_t       cb;
    logic signed [W-1:0]     x1, y1, x2, y2, dx, dy;
  } rec_t;

  // ---------------- stage 0: outcodes
  rec_t s0_q;
  logic s0_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s0_valid_q <= 1'b0;
    else         s0_valid_q <= start_i;
  end
  always_ff @(posedge clk_i) begin
    s0_q.x1 <= W'($signed(x_start_i));
    s0_q.y1 <= W'($signed(y_start_i));
    s0_q.x2 <= W'($signed(x_end_i));
    s0_q.y2 <= W'($signed(y_end_i));
    s0_q.dx <= W'($signed(x_end_i)) - W'($signed(x_start_i));
    s0_q.dy <= W'($signed(y_end_i)) - W'($signed(y_start_i));
    s0_q.ca <= outc(wide_t'($signed(x_start_i)), wide_t'($signed(y_start_i)),
                    wl, wt, wr, wb);
    s0_q.cb <= outc(wide_t'($signed(x_end_i)), wide_t'($signed(y_end_i)),
                    wl, wt, wr, wb);
  end

  // ---------------- follow unit: each endpoint gets a primary follow
  // (along its first edge) and a fallback follow, computed in parallel rows
  // row inputs: p + t*d/e
  typedef struct packed {
    logic signed [W-1:0] p;
    logic signed [W-1:0] t;
    logic signed [W-1:0] d;
    logic signed [W-1:0] e;
  } fol_t;

  function automatic fol_t prim(lswc_pkg::region_t c, logic signed [W-1:0] px,
                                logic signed [W-1:0] py, logic signed [W-1:0] dx,
                                logic signed [W-1:0] dy);
    fol_t f;
    logic signed [W-1:0] ey, ex;
    ey = c[lswc_pkg::CodeAbove] ? W'(top_q) : W'(bottom_q);
    ex = c[lswc_pkg::CodeLeft] ? W'(left_q) : W'(right_q);
    if (c[lswc_pkg::CodeAbove] | c[lswc_pkg::CodeBelow]) begin
      f.p = px; f.t = ey - py; f.d = dx; f.e = dy;
    end else begin
      f.p = py; f.t = ex - px; f.d = dy; f.e = dx;
    end
    return f;
  endfunction

  function automatic fol_t fall(lswc_pkg::region_t c, logic signed [W-1:0] px,
                                logic signed [W-1:0] py, logic signed [W-1:0] dx,
                                logic signed [W-1:0] dy);
    fol_t f;
    logic signed [W-1:0] ex;
    ex = c[lswc_pkg::CodeLeft] ? W'(left_q) : W'(right_q);
    f.p = py; f.t = ex - px; f.d = dy; f.e = dx;
    return f;
  endfunction

  localparam int unsigned NF = 4;  // a primary, a fallback, b primary, b fallback
  fol_t fin [NF];
  always_comb begin
    fin[0] = prim(s0_q.ca, s0_q.x1, s0_q.y1, s0_q.dx, s0_q.dy);
    fin[1] = fall(s0_q.ca, s0_q.x1, s0_q.y1, s0_q.dx, s0_q.dy);
    fin[2] = prim(s0_q.cb, s0_q.x2, s0_q.y2, s0_q.dx, s0_q.dy);
    fin[3] = fall(s0_q.cb, s0_q.x2, s0_q.y2, s0_q.dx, s0_q.dy);
  end

  // stage 1: magnitude product, sign, registered
  logic [PW-1:0]        mag_q  [NF];
  logic [DW-1:0]        den_q  [NF];
  logic                 neg_q  [NF];
  logic                 ez_q   [NF];
  logic signed [W-1:0]  p_q    [NF];
  rec_t                 s1_q;
  logic                 s1_valid_q;

  function automatic logic [W-1:0] mg(logic signed [W-1:0] v);
    return v[W-1] ? W'(-v) : W'(v);
  endfunction

  for (genvar f = 0; f < NF; f++) begin : g_mul
    always_ff @(posedge clk_i) begin
      mag_q[f] <= PW'(mg(fin[f].t)) * PW'(mg(fin[f].d));
      den_q[f] <= mg(fin[f].e);
      neg_q[f] <= (fin[f].t[W-1] ^ fin[f].d[W-1]) ^ fin[f].e[W-1];
      ez_q[f]  <= (fin[f].e == '0);
      p_q[f]   <= fin[f].p;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_valid_q <= 1'b0;
    else         s1_valid_q <= s0_valid_q;
  end
  always_ff @(posedge clk_i) begin
    s1_q <= s0_q;
  end

  // divider chain: one cell per quotient bit, msb first
  logic [PW-1:0] rem_c [NF][NumDiv+1];
  logic [PW-1:0] quo_c [NF][NumDiv+1];
  logic [DW-1:0] den_c [NF][NumDiv+1];
  logic          neg_c [NF][NumDiv+1];
  logic          ez_c  [NF][NumDiv+1];
  logic signed [W-1:0] p_c [NF][NumDiv+1];
  rec_t          rc    [NumDiv+1];
  logic          vc    [NumDiv+1];

  for (genvar f = 0; f < NF; f++) begin : g_row
    assign rem_c[f][0] = mag_q[f];
    assign quo_c[f][0] = '0;
    assign den_c[f][0] = den_q[f];
    assign neg_c[f][0] = neg_q[f];
    assign ez_c[f][0]  = ez_q[f];
    assign p_c[f][0]   = p_q[f];
    for (genvar k = 0; k < NumDiv; k++) begin : g_cell
      lswc_div_cell #(.NumW(PW), .DenW(DW)) u_cell (
        .clk_i   (clk_i),
        .rem_i   (rem_c[f][k]),
        .quo_i   (quo_c[f][k]),
        .den_i   (den_c[f][k]),
        .shift_i (SW'(NumDiv - 1 - k)),
        .rem_o   (rem_c[f][k+1]),
        .quo_o   (quo_c[f][k+1])
      );
      always_ff @(posedge clk_i) begin
        den_c[f][k+1] <= den_c[f][k];
        neg_c[f][k+1] <= neg_c[f][k];
        ez_c[f][k+1]  <= ez_c[f][k];
        p_c[f][k+1]   <= p_c[f][k];
      end
    end
  end

  assign rc[0] = s1_q;
  assign vc[0] = s1_valid_q;
  for (genvar k = 0; k < NumDiv; k++) begin : g_ctl
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vc[k+1] <= 1'b0;
      else         vc[k+1] <= vc[k];
    end
    always_ff @(posedge clk_i) rc[k+1] <= rc[k];
  end

  // finish: saturate, apply sign, choose, check
  function automatic wide_t fin_val(logic [PW-1:0] q, logic neg, logic ez,
                                    logic signed [W-1:0] p);
    logic [QW-1:0] qs;
    wide_t off;
    qs = QW'(q);
    if (qs > (QW'(1) << lswc_pkg::CapBits)) qs = QW'(1) << lswc_pkg::CapBits;
    off = wide_t'(qs[lswc_pkg::CapBits:0]);
    if (ez) return wide_t'(p);
    return neg ? wide_t'(p) - off : wide_t'(p) + off;
  endfunction

  wide_t fo [NF];
  always_comb begin
    for (int f = 0; f < NF; f++) begin
      fo[f] = fin_val(quo_c[f][NumDiv], neg_c[f][NumDiv], ez_c[f][NumDiv],
                      p_c[f][NumDiv]);
    end
  end

  rec_t  re;
  wide_t ax, ay, bx, by;
  logic  vis;

  task automatic place(input lswc_pkg::region_t c, input wide_t px, input wide_t py,
                       input wide_t pr, input wide_t fb, output wide_t rx,
                       output wide_t ry);
    rx = px; ry = py;
    if (c == '0) begin
    end else if (c[lswc_pkg::CodeAbove] | c[lswc_pkg::CodeBelow]) begin
      rx = pr;
      ry = c[lswc_pkg::CodeAbove] ? wt : wb;
      if (c[lswc_pkg::CodeLeft] && pr < wl) begin
        rx = wl; ry = fb;
      end else if (c[lswc_pkg::CodeRight] && pr > wr) begin
        rx = wr; ry = fb;
      end
    end else begin
      rx = c[lswc_pkg::CodeLeft] ? wl : wr;
      ry = pr;
    end
  endtask

  always_comb begin
    re = rc[NumDiv];
    place(re.ca, wide_t'(re.x1), wide_t'(re.y1), fo[0], fo[1], ax, ay);
    place(re.cb, wide_t'(re.x2), wide_t'(re.y2), fo[2], fo[3], bx, by);
    vis = ((re.ca & re.cb) == '0)
       && ax >= wl && ax <= wr && ay >= wt && ay <= wb
       && bx >= wl && bx <= wr && by >= wt && by <= wb;
  end

  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= vc[NumDiv];
  end
  always_ff @(posedge clk_i) begin
    visible_o      <= vis;
    clip_x_start_o <= vis ? ax[COORD_BITS-1:0] : '0;
    clip_y_start_o <= vis ? ay[COORD_BITS-1:0] : '0;
    clip_x_end_o   <= vis ? bx[COORD_BITS-1:0] : '0;
    clip_y_end_o   <= vis ? by[COORD_BITS-1:0] : '0;
    start_region_o <= re.ca;
    end_region_o   <= re.cb;
  end
  assign done_o = done_q;

endmodule

>>> sv/lswc_checker.sv
// port-level checks for the line segment window clipper
module lswc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       busy_o,
  input logic       done_o,
  input logic       visible_o,
  input logic [3:0] start_region_o,
  input logic [3:0] end_region_o
);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");

  a_reject_shared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && ((start_region_o & end_region_o) != 4'd0) |-> !visible_o)
    else $error("shared outcode bit but visible");

  a_lr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(start_region_o[0] && start_region_o[1]))
    else $error("left and right both set");

  a_ab_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(end_region_o[2] && end_region_o[3]))
    else $error("above and below both set");

endmodule

bind line_segment_window_clipper lswc_checker u_lswc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .busy_o         (busy_o),
  .done_o         (done_o),
  .visible_o      (visible_o),
  .start_region_o (start_region_o),
  .end_region_o   (end_region_o)
);

>>> tb/line_segment_window_clipper_test.sv
// self-checking testbench for the line segment window clipper
module line_segment_window_clipper_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW = 16;
  localparam longint unsigned OFS_CAP = 64'd1 << lswc_pkg::CapBits;
  // divider rows are about two coordinate widths deep
  localparam int unsigned DRAIN = 200;

  typedef struct packed {
    logic              visible;
    logic [CW-1:0]     ax, ay, bx, by;
    lswc_pkg::region_t ca, cb;
  } clip_word_t;

  // window held by the predictor, kept in step with every register write
  longint win_l = 50, win_t = 50, win_r = 100, win_b = 80;

  function automatic lswc_pkg::region_t region_of(longint x, longint y);
    lswc_pkg::region_t c;
    c = '0;
    if (x < win_l) c[lswc_pkg::CodeLeft] = 1'b1;
    else if (x > win_r) c[lswc_pkg::CodeRight] = 1'b1;
    if (y < win_t) c[lswc_pkg::CodeAbove] = 1'b1;
    else if (y > win_b) c[lswc_pkg::CodeBelow] = 1'b1;
    return c;
  endfunction

  // p + trunc(t*d/e), offset saturated, p kept on zero divisor
  function automatic longint along(longint p, longint t, longint d, longint e);
    longint unsigned q;
    bit neg;
    if (e == 0) return p;
    q = ((t < 0 ? -t : t) * (d < 0 ? -d : d)) / (e < 0 ? -e : e);
    if (q > OFS_CAP) q = OFS_CAP;
    neg = ((t < 0) != (d < 0)) != (e < 0);
    return neg ? p - longint'(q) : p + longint'(q);
  endfunction

  task automatic snap_to_edge(lswc_pkg::region_t c, longint px, longint py, longint dx,
                              longint dy, output longint rx, output longint ry);
    longint ey, ex;
    rx = px;
    ry = py;
    if (c == 0) return;
    if (c[lswc_pkg::CodeAbove] || c[lswc_pkg::CodeBelow]) begin
      ey = c[lswc_pkg::CodeAbove] ? win_t : win_b;
      ex = along(px, ey - py, dx, dy);
      rx = ex;
      ry = ey;
      // corner: fall back onto the vertical edge
      if (c[lswc_pkg::CodeLeft] && ex < win_l) begin
        rx = win_l;
        ry = along(py, win_l - px, dy, dx);
      end else if (c[lswc_pkg::CodeRight] && ex > win_r) begin
        rx = win_r;
        ry = along(py, win_r - px, dy, dx);
      end
      return;
    end
    ex = c[lswc_pkg::CodeLeft] ? win_l : win_r;
    rx = ex;
    ry = along(py, ex - px, dy, dx);
  endtask

  function automatic bit in_window(longint x, longint y);
    return x >= win_l && x <= win_r && y >= win_t && y <= win_b;
  endfunction

  task automatic clip_segment(logic [CW-1:0] xs, ys, xe, ye, output clip_word_t w);
    longint x1, y1, x2, y2, ax, ay, bx, by;
    x1 = longint'($signed(xs));
    y1 = longint'($signed(ys));
    x2 = longint'($signed(xe));
    y2 = longint'($signed(ye));
    w = '0;
    w.ca = region_of(x1, y1);
    w.cb = region_of(x2, y2);
    if ((w.ca & w.cb) == 0) begin
      snap_to_edge(w.ca, x1, y1, x2 - x1, y2 - y1, ax, ay);
      snap_to_edge(w.cb, x2, y2, x2 - x1, y2 - y1, bx, by);
      if (in_window(ax, ay) && in_window(bx, by)) begin
        w.visible = 1'b1;
        w.ax = ax[CW-1:0];
        w.ay = ay[CW-1:0];
        w.bx = bx[CW-1:0];
        w.by = by[CW-1:0];
      end
    end
  endtask

  // scoreboard: pending clipped words in order of acceptance
  class clip_board;
    clip_word_t pending[$];
    int unsigned errors, checked, shown_visible;

    function void note_segment(clip_word_t w);
      pending.push_back(w);
    endfunction

    function void check_word(clip_word_t got);
      clip_word_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %h", got);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.visible) shown_visible++;
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("word %0d: expected vis %b %h %h %h %h reg %h %h, got vis %b %h %h %h %h reg %h %h",
                   checked, want.visible, want.ax, want.ay, want.bx, want.by, want.ca,
                   want.cb, got.visible, got.ax, got.ay, got.bx, got.by, got.ca, got.cb);
      end
    endfunction
  endclass

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic start_i = 1'b0, cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [CW-1:0] cfg_data_i = '0;
  logic [CW-1:0] x_start_i = '0, y_start_i = '0, x_end_i = '0, y_end_i = '0;
  logic busy_o, done_o, visible_o;
  logic [CW-1:0] clip_x_start_o, clip_y_start_o, clip_x_end_o, clip_y_end_o;
  logic [3:0] start_region_o, end_region_o;

  clip_board board = new();

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  line_segment_window_clipper #(.COORD_BITS(CW)) dut (.*);

  // results are sampled at the edge that ends their cycle
  always @(posedge clk_i)
    if (rst_ni && done_o)
      board.check_word({visible_o, clip_x_start_o, clip_y_start_o, clip_x_end_o,
                        clip_y_end_o, start_region_o, end_region_o});

  task automatic write_reg(logic [1:0] idx, logic [CW-1:0] val);
    cfg_we_i  <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      lswc_pkg::RegLeft:   win_l = longint'($signed(val));
      lswc_pkg::RegTop:    win_t = longint'($signed(val));
      lswc_pkg::RegRight:  win_r = longint'($signed(val));
      default:             win_b = longint'($signed(val));
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_window(logic [CW-1:0] l, t, r, b);
    write_reg(lswc_pkg::RegLeft, l);
    write_reg(lswc_pkg::RegTop, t);
    write_reg(lswc_pkg::RegRight, r);
    write_reg(lswc_pkg::RegBottom, b);
  endtask

  // drive one word, holding start until the block takes it
  task automatic send_segment(logic [CW-1:0] xs, ys, xe, ye, bit keep_start);
    clip_word_t w;
    start_i   <= 1'b1;
    x_start_i <= xs;
    y_start_i <= ys;
    x_end_i   <= xe;
    y_end_i   <= ye;
    do @(posedge clk_i); while (busy_o);
    clip_segment(xs, ys, xe, ye, w);
    board.note_segment(w);
    if (!keep_start) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // random idle gap: mostly none or short, now and then long
  task automatic idle_gap();
    int unsigned n;
    n = $urandom_range(0, 9);
    if (n < 5) n = 0;
    else if (n < 9) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  // coordinate near a window edge, or anywhere
  function automatic logic [CW-1:0] pick(longint lo, longint hi);
    case ($urandom_range(0, 4))
      0: return CW'($urandom);
      1: return CW'(lo + $signed($urandom_range(0, 8)) - 4);
      2: return CW'(hi + $signed($urandom_range(0, 8)) - 4);
      default: return CW'(lo - 60 + longint'($urandom_range(0, 120)) +
                          (hi - lo) * longint'($urandom_range(0, 2)) / 2);
    endcase
  endfunction

  task automatic random_phase(int unsigned count);
    bit burst;
    for (int unsigned i = 0; i < count; i++) begin
      burst = (i % 200) < 50;
      send_segment(pick(win_l, win_r), pick(win_t, win_b),
                   pick(win_l, win_r), pick(win_t, win_b), burst);
      if (!burst) idle_gap();
    end
    start_i <= 1'b0;
    @(posedge clk_i);
  endtask

  localparam logic [CW-1:0] MAXC = 16'h7fff, MINC = 16'h8000;

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset window, every outcode region, corners, degenerate lines
    send_segment(60, 60, 90, 70, 0);       // fully inside
    send_segment(0, 60, 200, 70, 0);       // left and right crossing
    send_segment(70, 0, 75, 200, 0);       // above and below crossing
    send_segment(0, 0, 10, 10, 0);         // trivial reject, shared bits
    send_segment(0, 0, 150, 130, 0);       // two corners
    send_segment(40, 45, 110, 90, 0);      // corner falls back to vertical edge
    send_segment(0, 100, 200, 0, 0);       // negative slope
    send_segment(75, 60, 75, 60, 0);       // single point
    send_segment(75, 0, 75, 60, 1);        // vertical, zero dx
    send_segment(0, 65, 60, 65, 1);        // horizontal, zero dy
    send_segment(MINC, MINC, MAXC, MAXC, 1);
    send_segment(MAXC, MINC, MINC, MAXC, 0);
    send_segment(MINC, 60, MAXC, 60, 0);
    send_segment(60, MAXC, 61, MINC, 0);
    send_segment(49, 49, 101, 81, 0);      // just outside every edge
    send_segment(MINC, 0, MAXC, 1, 0);     // huge offset path
    start_i <= 1'b0;
    drain();

    random_phase(500);
    drain();
    // extreme window: whole plane
    set_window(MINC, MINC, MAXC, MAXC);
    send_segment(MINC, MAXC, MAXC, MINC, 0);
    random_phase(400);
    drain();
    // inverted window keeps test priority
    set_window(100, 80, 50, 50);
    send_segment(75, 65, 75, 65, 0);
    random_phase(300);
    drain();
    // single-point window and a negative wide window
    set_window(0, 0, 0, 0);
    random_phase(200);
    drain();
    set_window(-20000, -3, 30000, 3);
    random_phase(300);
    drain();
    set_window(CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom));
    random_phase(300);
    drain();

    $display("checked %0d clipped words over six window settings, %0d visible",
             board.checked, board.shown_visible);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("line_segment_window_clipper: match");
    else
      $display("line_segment_window_clipper: mismatch");
    $finish;
  end

  initial begin
    #2ms;
    $display("line_segment_window_clipper: mismatch");
    $finish;
  end

endmodule

>>> line_segment_window_clipper.f
sv/lswc_pkg.sv
sv/lswc_div_cell.sv
sv/line_segment_window_clipper.sv
sv/lswc_checker.sv
tb/line_segment_window_clipper_test.sv
